>>> rtl/core/wsq_pkg.sv
// ----------------------------------------------------------------------------
// wsq_pkg
// Shared types and codes of the two-class weighted service queue.
// ----------------------------------------------------------------------------
package wsq_pkg;

    localparam int DATA_W = 8;
    localparam int ID_W   = 16;
    localparam int AGE_W  = 8;
    localparam int STAT_W = 3;
    localparam int CIDX_W = 1;

    // request codes
    localparam logic FUNC_ADD   = 1'b0;
    localparam logic FUNC_SERVE = 1'b1;

    // result status codes
    localparam logic [STAT_W-1:0] ST_ADDED       = 3'd0;
    localparam logic [STAT_W-1:0] ST_DROPPED     = 3'd1;
    localparam logic [STAT_W-1:0] ST_SERVED_PRIO = 3'd2;
    localparam logic [STAT_W-1:0] ST_SERVED_NORM = 3'd3;
    localparam logic [STAT_W-1:0] ST_NONE        = 3'd4;

    // configuration register indexes
    localparam logic [CIDX_W-1:0] CFG_QUOTA  = 1'b0;
    localparam logic [CIDX_W-1:0] CFG_THRESH = 1'b1;

    localparam logic [DATA_W-1:0] QUOTA_RESET  = 8'd3;
    localparam logic [AGE_W-1:0]  THRESH_RESET = 8'd60;

    typedef struct packed {
        logic             func;
        logic [ID_W-1:0]  client_id;
        logic [AGE_W-1:0] client_age;
    } t_in_item;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [ID_W-1:0]   served_id;
        logic [AGE_W-1:0]  served_age;
    } t_out_item;

    // classified command from front to back
    typedef struct packed {
        logic             serve;
        logic             to_prio;
        logic [ID_W-1:0]  id;
        logic [AGE_W-1:0] age;
    } t_cmd;

    typedef struct packed {
        logic [ID_W-1:0]  id;
        logic [AGE_W-1:0] age;
    } t_entry;

    // credit reload request from the configuration port
    typedef struct packed {
        logic              we;
        logic [DATA_W-1:0] value;
    } t_quota_wr;

endpackage

>>> rtl/core/two_class_weighted_service_queue_top.sv
// ----------------------------------------------------------------------------
// two_class_weighted_service_queue_top
// Two-class queue with credit-weighted service between a priority and a
// normal FIFO of (id, age) entries.
// ----------------------------------------------------------------------------
// Each request yields exactly one result. Add requests go to the priority
// FIFO when the age is strictly above age_threshold, otherwise to the normal
// FIFO; a full target drops the entry with status "dropped". Serve requests
// take from the priority FIFO while credit remains (one credit per priority
// serve), fall back to the normal FIFO when the priority FIFO is empty, and
// once the credit is spent force one normal serve and reload the credit from
// priority_quota. Throughput is one request per cycle sustained while results
// are taken: the back end executes one command per clock when not stalled,
// with one write and one registered read per FIFO store, and a result is
// registered as its command leaves the command queue. A two-entry command
// queue between the front (classify) and the back (execute) lets either side
// stall on its own, and the result register lets a new request be taken
// while the previous result waits. Configuration is written through a
// simple write port; writing priority_quota also reloads the credit counter.
module two_class_weighted_service_queue_top #(
    parameter int QUEUE_DEPTH = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // request channel
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  wsq_pkg::t_in_item  i_in_item,
    // result channel
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output wsq_pkg::t_out_item o_out_item,
    // configuration write port
    input  logic               i_cfg_we,
    input  logic [0:0]         i_cfg_idx,
    input  logic [7:0]         i_cfg_data
);
    import wsq_pkg::*;

    // configuration registers
    logic [7:0] r_quota;
    logic [7:0] r_thresh;
    t_quota_wr  quota_wr;

    // front-to-back command transfer
    logic cmd_valid;
    logic cmd_ready;
    t_cmd cmd;

    // decode register writes; a quota write also reloads the credit
    always_comb begin
        quota_wr.we    = 1'b0;
        quota_wr.value = i_cfg_data;
        case (i_cfg_idx)
            CFG_QUOTA:  quota_wr.we = i_cfg_we;
            default:    quota_wr.we = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_quota  <= QUOTA_RESET;
            r_thresh <= THRESH_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_QUOTA:  r_quota  <= i_cfg_data;
                CFG_THRESH: r_thresh <= i_cfg_data;
                default:    r_quota  <= r_quota;
            endcase
        end
    end

    // front: take requests, classify adds by age, hold them in the queue
    wsq_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_in_item      (i_in_item),
        .i_age_threshold(r_thresh),
        .o_cmd_valid    (cmd_valid),
        .i_cmd_ready    (cmd_ready),
        .o_cmd          (cmd)
    );

    // back: FIFO stores, credit counter and result register
    wsq_back #(
        .QUEUE_DEPTH(QUEUE_DEPTH)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd_valid(cmd_valid),
        .o_cmd_ready(cmd_ready),
        .i_cmd      (cmd),
        .i_quota    (r_quota),
        .i_quota_wr (quota_wr),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_out_item (o_out_item)
    );

endmodule

>>> rtl/core/wsq_front.sv
// ----------------------------------------------------------------------------
// wsq_front
// Accepts requests, classifies adds by age and queues them for the back end.
// ----------------------------------------------------------------------------
module wsq_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  wsq_pkg::t_in_item i_in_item,
    input  logic [7:0]        i_age_threshold,
    output logic              o_cmd_valid,
    input  logic              i_cmd_ready,
    output wsq_pkg::t_cmd     o_cmd
);
    import wsq_pkg::*;

    t_cmd       r_q [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_cnt;
    logic [1:0] n_cnt;
    logic       push;
    logic       pop;
    t_cmd       cmd_in;

    assign o_in_ready  = (r_cnt != 2'd2);
    assign o_cmd_valid = (r_cnt != 2'd0);
    assign o_cmd       = r_q[r_rd_ptr];
    assign push        = i_in_valid && o_in_ready;
    assign pop         = o_cmd_valid && i_cmd_ready;

    always_comb begin
        cmd_in.serve   = (i_in_item.func == FUNC_SERVE);
        cmd_in.to_prio = (i_in_item.client_age > i_age_threshold);
        cmd_in.id      = i_in_item.client_id;
        cmd_in.age     = i_in_item.client_age;
        n_cnt = r_cnt;
        if (push && !pop) begin
            n_cnt = r_cnt + 2'd1;
        end else if (pop && !push) begin
            n_cnt = r_cnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wr_ptr] <= cmd_in;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_cnt    <= 2'd0;
        end else begin
            if (push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            r_cnt <= n_cnt;
        end
    end

endmodule

>>> rtl/core/wsq_back.sv
// ----------------------------------------------------------------------------
// wsq_back
// Both entry FIFOs and the credit counter; one command a cycle unless stalled.
// ----------------------------------------------------------------------------
module wsq_back #(
    parameter int QUEUE_DEPTH = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cmd_valid,
    output logic               o_cmd_ready,
    input  wsq_pkg::t_cmd      i_cmd,
    input  logic [7:0]         i_quota,
    input  wsq_pkg::t_quota_wr i_quota_wr,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output wsq_pkg::t_out_item o_out_item
);
    import wsq_pkg::*;

    localparam int PW = $clog2(QUEUE_DEPTH);
    localparam int FW = $clog2(QUEUE_DEPTH + 1);
    localparam logic [FW-1:0] FULL = FW'(QUEUE_DEPTH);
    localparam logic [PW-1:0] LAST = PW'(QUEUE_DEPTH - 1);
    localparam logic [PW-1:0] PTR_ONE  = PW'(1);
    localparam logic [FW-1:0] FILL_ONE = FW'(1);

    t_entry r_p_mem [QUEUE_DEPTH];
    t_entry r_n_mem [QUEUE_DEPTH];

    logic [PW-1:0] r_p_head, r_p_tail, r_n_head, r_n_tail;
    logic [FW-1:0] r_p_fill, r_n_fill;
    logic [7:0]    r_credit;
    t_entry        r_p_rdata, r_n_rdata;
    logic          r_out_valid;
    logic [2:0]    r_status;
    logic          r_sel_p, r_sel_n;

    logic       fire;
    logic       p_push, n_push, p_pop, n_pop;
    logic [2:0] n_status;
    logic [7:0] n_credit;
    logic       p_empty, n_empty, p_full, n_full;
    t_entry     wr_entry;

    assign fire        = i_cmd_valid && (!r_out_valid || i_out_ready);
    assign o_cmd_ready = !r_out_valid || i_out_ready;
    assign p_empty     = (r_p_fill == '0);
    assign n_empty     = (r_n_fill == '0);
    assign p_full      = (r_p_fill == FULL);
    assign n_full      = (r_n_fill == FULL);
    assign wr_entry    = '{id: i_cmd.id, age: i_cmd.age};

    always_comb begin
        p_push   = 1'b0;
        n_push   = 1'b0;
        p_pop    = 1'b0;
        n_pop    = 1'b0;
        n_status = ST_NONE;
        n_credit = r_credit;
        if (!i_cmd.serve) begin
            if (i_cmd.to_prio) begin
                p_push   = !p_full;
                n_status = p_full ? ST_DROPPED : ST_ADDED;
            end else begin
                n_push   = !n_full;
                n_status = n_full ? ST_DROPPED : ST_ADDED;
            end
        end else if (r_credit != 8'd0) begin
            if (!p_empty) begin
                p_pop    = 1'b1;
                n_credit = r_credit - 8'd1;
                n_status = ST_SERVED_PRIO;
            end else if (!n_empty) begin
                n_pop    = 1'b1;
                n_status = ST_SERVED_NORM;
            end
        end else begin
            // credit spent: force a normal serve and reload
            n_pop    = !n_empty;
            n_status = n_empty ? ST_NONE : ST_SERVED_NORM;
            n_credit = i_quota;
        end
    end

    // entry stores: one write and one registered read per cycle each
    always_ff @(posedge i_clk) begin
        if (fire && p_push) begin
            r_p_mem[r_p_tail] <= wr_entry;
        end
        if (fire && p_pop) begin
            r_p_rdata <= r_p_mem[r_p_head];
        end
        if (fire && n_push) begin
            r_n_mem[r_n_tail] <= wr_entry;
        end
        if (fire && n_pop) begin
            r_n_rdata <= r_n_mem[r_n_head];
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_status <= n_status;
            r_sel_p  <= p_pop;
            r_sel_n  <= n_pop;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_head    <= '0;
            r_p_tail    <= '0;
            r_p_fill    <= '0;
            r_n_head    <= '0;
            r_n_tail    <= '0;
            r_n_fill    <= '0;
            r_credit    <= QUOTA_RESET;
            r_out_valid <= 1'b0;
        end else begin
            if (fire) begin
                r_out_valid <= 1'b1;
                if (p_push) begin
                    r_p_tail <= (r_p_tail == LAST) ? '0 : r_p_tail + PTR_ONE;
                    r_p_fill <= r_p_fill + FILL_ONE;
                end
                if (p_pop) begin
                    r_p_head <= (r_p_head == LAST) ? '0 : r_p_head + PTR_ONE;
                    r_p_fill <= r_p_fill - FILL_ONE;
                end
                if (n_push) begin
                    r_n_tail <= (r_n_tail == LAST) ? '0 : r_n_tail + PTR_ONE;
                    r_n_fill <= r_n_fill + FILL_ONE;
                end
                if (n_pop) begin
                    r_n_head <= (r_n_head == LAST) ? '0 : r_n_head + PTR_ONE;
                    r_n_fill <= r_n_fill - FILL_ONE;
                end
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (i_quota_wr.we) begin
                r_credit <= i_quota_wr.value;
            end else if (fire) begin
                r_credit <= n_credit;
            end
        end
    end

    assign o_out_valid           = r_out_valid;
    assign o_out_item.status     = r_status;
    assign o_out_item.served_id  = r_sel_p ? r_p_rdata.id  : (r_sel_n ? r_n_rdata.id  : '0);
    assign o_out_item.served_age = r_sel_p ? r_p_rdata.age : (r_sel_n ? r_n_rdata.age : '0);

`ifndef NO_ASSERTIONS
    a_p_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_p_fill <= FULL)
        else $error("priority fill above depth");

    a_n_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_n_fill <= FULL)
        else $error("normal fill above depth");

    a_credit_use: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rst_n && fire && p_pop && !i_quota_wr.we |=> r_credit == $past(r_credit) - 8'd1)
        else $error("priority serve did not use one credit");

    a_credit_reload: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rst_n && fire && i_cmd.serve && r_credit == 8'd0 && !i_quota_wr.we
        |=> r_credit == $past(i_quota))
        else $error("credit not reloaded after forced normal serve");
`endif

endmodule
